/* rtl/core/ewq_pkg.sv */
// Shared types and constants of the event wait-queue unit.
package ewq_pkg;

  // Width of a task id as it travels on the ports and in the slot store.
  localparam int TASK_W = 4;

  // Number of release items a single send may report.
  localparam int MAX_RESULTS = 8;
  localparam int NREL_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_WAIT   = 2'd0,
    OP_SEND   = 2'd1,
    OP_GIVEUP = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // One result item handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic              status;
    logic              rel_valid;
    logic [TASK_W-1:0] rel_task;
    logic              last;
  } push_t;

endpackage

/* rtl/core/ewq_store.sv */
// State memories of the event wait-queue unit: slot bitmaps, slot task ids, task masks.
module ewq_store #(
  parameter int NUM_EVENTS  = 32,
  parameter int QUEUE_SLOTS = 8,
  parameter int NUM_TASKS   = 16,
  parameter int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1,
  parameter int TW = $clog2(NUM_TASKS),
  parameter int AW = (NUM_EVENTS * QUEUE_SLOTS > 1) ? $clog2(NUM_EVENTS * QUEUE_SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        used_re,
  input  logic [EW-1:0]               used_raddr,
  output logic [QUEUE_SLOTS-1:0]      used_rdata,
  input  logic                        used_we,
  input  logic [EW-1:0]               used_waddr,
  input  logic [QUEUE_SLOTS-1:0]      used_wdata,
  input  logic                        st_re,
  input  logic [AW-1:0]               st_raddr,
  output logic [ewq_pkg::TASK_W-1:0]  st_rdata,
  input  logic                        st_we,
  input  logic [AW-1:0]               st_waddr,
  input  logic [ewq_pkg::TASK_W-1:0]  st_wdata,
  input  logic                        tm_re,
  input  logic [TW-1:0]               tm_raddr,
  output logic [NUM_EVENTS-1:0]       tm_rdata,
  input  logic                        tm_we,
  input  logic [TW-1:0]               tm_waddr,
  input  logic [NUM_EVENTS-1:0]       tm_wdata
);

  localparam int ST_DEPTH = NUM_EVENTS * QUEUE_SLOTS;

  logic [QUEUE_SLOTS-1:0]     used_mem [NUM_EVENTS];
  logic [NUM_EVENTS-1:0]      used_vld;
  logic [QUEUE_SLOTS-1:0]     used_q;
  logic                       used_q_vld;

  logic [ewq_pkg::TASK_W-1:0] st_mem [ST_DEPTH];

  logic [NUM_EVENTS-1:0]      tm_mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]       tm_vld;
  logic [NUM_EVENTS-1:0]      tm_q;
  logic                       tm_q_vld;

  // Bitmap and mask entries that were never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      used_vld <= '0;
      tm_vld   <= '0;
    end else begin
      if (used_we) used_vld[used_waddr] <= 1'b1;
      if (tm_we) tm_vld[tm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (used_re) begin
      used_q     <= used_mem[used_raddr];
      used_q_vld <= used_vld[used_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rdata <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (tm_we) tm_mem[tm_waddr] <= tm_wdata;
    if (tm_re) begin
      tm_q     <= tm_mem[tm_raddr];
      tm_q_vld <= tm_vld[tm_raddr];
    end
  end

  assign used_rdata = used_q_vld ? used_q : '0;
  assign tm_rdata   = tm_q_vld ? tm_q : '0;

endmodule

/* rtl/core/ewq_seq.sv */
// Sequencer of the event wait-queue unit: read-modify-write walks over the state memories.
module ewq_seq #(
  parameter int NUM_EVENTS  = 32,
  parameter int QUEUE_SLOTS = 8,
  parameter int NUM_TASKS   = 16,
  parameter int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1,
  parameter int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1,
  parameter int TW = $clog2(NUM_TASKS),
  parameter int AW = (NUM_EVENTS * QUEUE_SLOTS > 1) ? $clog2(NUM_EVENTS * QUEUE_SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        idle,
  input  logic [1:0]                  op,
  input  logic [ewq_pkg::TASK_W-1:0]  task_id,
  input  logic [31:0]                 event_mask,
  input  logic [4:0]                  event_number,
  output ewq_pkg::push_t              push,
  input  logic                        push_ok,
  output logic                        used_re,
  output logic [EW-1:0]               used_raddr,
  input  logic [QUEUE_SLOTS-1:0]      used_rdata,
  output logic                        used_we,
  output logic [EW-1:0]               used_waddr,
  output logic [QUEUE_SLOTS-1:0]      used_wdata,
  output logic                        st_re,
  output logic [AW-1:0]               st_raddr,
  input  logic [ewq_pkg::TASK_W-1:0]  st_rdata,
  output logic                        st_we,
  output logic [AW-1:0]               st_waddr,
  output logic [ewq_pkg::TASK_W-1:0]  st_wdata,
  output logic                        tm_re,
  output logic [TW-1:0]               tm_raddr,
  input  logic [NUM_EVENTS-1:0]       tm_rdata,
  output logic                        tm_we,
  output logic [TW-1:0]               tm_waddr,
  output logic [NUM_EVENTS-1:0]       tm_wdata
);

  localparam logic [QUEUE_SLOTS-1:0] SLOT_ONE  = QUEUE_SLOTS'(1);
  localparam logic [NUM_EVENTS-1:0]  EVENT_ONE = NUM_EVENTS'(1);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_G_MASK = 15'b000000000000010,
    ST_G_NEXT = 15'b000000000000100,
    ST_G_USED = 15'b000000000001000,
    ST_G_SLOT = 15'b000000000010000,
    ST_C_NEXT = 15'b000000000100000,
    ST_C_USED = 15'b000000001000000,
    ST_A_NEXT = 15'b000000010000000,
    ST_A_USED = 15'b000000100000000,
    ST_S_USED = 15'b000001000000000,
    ST_S_SLOT = 15'b000010000000000,
    ST_S_TASK = 15'b000100000000000,
    ST_S_MASK = 15'b001000000000000,
    ST_S_PUSH = 15'b010000000000000,
    ST_FINAL  = 15'b100000000000000
  } state_t;

  state_t                     state;
  logic [1:0]                 op_r;
  logic [ewq_pkg::TASK_W-1:0] tid_r;
  logic [TW-1:0]              tidx;
  logic [NUM_EVENTS-1:0]      wmask;
  logic [EW-1:0]              evn;
  logic [NUM_EVENTS-1:0]      scan;
  logic [EW-1:0]              cur_e;
  logic [QUEUE_SLOTS-1:0]     pending;
  logic [QUEUE_SLOTS-1:0]     cur_used;
  logic                       cmp_vld;
  logic [SW-1:0]              cmp_s;
  logic [ewq_pkg::TASK_W-1:0] t_reg;
  logic                       pend_vld;
  logic [ewq_pkg::TASK_W-1:0] pend_task;
  logic [ewq_pkg::TASK_W-1:0] new_task;
  logic [ewq_pkg::NREL_W-1:0] nrel;
  logic                       fin_status;
  logic                       fin_rv;
  logic [ewq_pkg::TASK_W-1:0] fin_rt;

  logic                       task_ok;
  logic                       ev_ok;
  logic [EW-1:0]              e_pick;
  logic [SW-1:0]              s_pick;
  logic [SW-1:0]              free_s;
  logic [QUEUE_SLOTS-1:0]     cur_used_n;
  logic [NUM_EVENTS-1:0]      m_n;
  logic                       st_task_ok;

  function automatic logic [EW-1:0] low_set_ev(input logic [NUM_EVENTS-1:0] v);
    logic [EW-1:0] r;
    r = '0;
    for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
      if (v[i]) r = EW'(i);
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] low_set_slot(input logic [QUEUE_SLOTS-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) r = SW'(i);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [EW-1:0] e, input logic [SW-1:0] s);
    return AW'(32'(e) * QUEUE_SLOTS + 32'(s));
  endfunction

  assign task_ok    = 32'(task_id) < NUM_TASKS;
  assign ev_ok      = 32'(event_number) < NUM_EVENTS;
  assign e_pick     = low_set_ev(scan);
  assign s_pick     = low_set_slot(pending);
  assign free_s     = low_set_slot(~used_rdata);
  assign st_task_ok = 32'(st_rdata) < NUM_TASKS;
  assign m_n        = tm_rdata & ~(EVENT_ONE << evn);
  assign idle       = (state == ST_IDLE);

  // Give-up compares the slot read in the previous cycle against the task.
  always_comb begin
    cur_used_n = cur_used;
    if (cmp_vld && (st_rdata == tid_r)) cur_used_n = cur_used & ~(SLOT_ONE << cmp_s);
  end

  always_comb begin
    used_re    = 1'b0;
    used_raddr = e_pick;
    used_we    = 1'b0;
    used_waddr = cur_e;
    used_wdata = '0;
    st_re      = 1'b0;
    st_raddr   = slot_addr(cur_e, s_pick);
    st_we      = 1'b0;
    st_waddr   = slot_addr(cur_e, free_s);
    st_wdata   = tid_r;
    tm_re      = 1'b0;
    tm_raddr   = tidx;
    tm_we      = 1'b0;
    tm_waddr   = tidx;
    tm_wdata   = '0;
    push       = '0;
    unique case (state)
      ST_IDLE: begin
        tm_raddr   = TW'(task_id);
        used_raddr = EW'(event_number);
        if (in_valid && task_ok &&
            ((op == ewq_pkg::OP_WAIT) || (op == ewq_pkg::OP_GIVEUP))) tm_re = 1'b1;
        if (in_valid && ev_ok && (op == ewq_pkg::OP_SEND)) used_re = 1'b1;
      end
      ST_G_NEXT: begin
        if (scan == '0) tm_we = 1'b1;
        else used_re = 1'b1;
      end
      ST_G_SLOT: begin
        if (pending == '0) begin
          used_we    = 1'b1;
          used_wdata = cur_used_n;
        end else begin
          st_re = 1'b1;
        end
      end
      ST_C_NEXT: begin
        if (scan == '0) begin
          tm_we    = 1'b1;
          tm_wdata = wmask;
        end else begin
          used_re = 1'b1;
        end
      end
      ST_A_NEXT: begin
        if (scan != '0) used_re = 1'b1;
      end
      ST_A_USED: begin
        used_we    = 1'b1;
        used_wdata = used_rdata | (SLOT_ONE << free_s);
        st_we      = 1'b1;
      end
      ST_S_SLOT: begin
        used_waddr = evn;
        st_raddr   = slot_addr(evn, s_pick);
        if (pending == '0) used_we = 1'b1;
        else st_re = 1'b1;
      end
      ST_S_TASK: begin
        tm_raddr = TW'(st_rdata);
        if (st_task_ok) tm_re = 1'b1;
      end
      ST_S_MASK: begin
        tm_waddr = TW'(t_reg);
        tm_wdata = m_n;
        if (tm_rdata != '0) tm_we = 1'b1;
      end
      ST_S_PUSH: begin
        push.valid     = 1'b1;
        push.rel_valid = 1'b1;
        push.rel_task  = pend_task;
      end
      ST_FINAL: begin
        push.valid     = 1'b1;
        push.status    = fin_status;
        push.rel_valid = fin_rv;
        push.rel_task  = fin_rt;
        push.last      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cmp_vld  <= 1'b0;
      pend_vld <= 1'b0;
      nrel     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_r       <= op;
            tid_r      <= task_id;
            tidx       <= TW'(task_id);
            wmask      <= event_mask[NUM_EVENTS-1:0];
            evn        <= EW'(event_number);
            nrel       <= '0;
            pend_vld   <= 1'b0;
            cmp_vld    <= 1'b0;
            fin_status <= 1'b0;
            fin_rv     <= 1'b0;
            fin_rt     <= '0;
            if (task_ok && ((op == ewq_pkg::OP_WAIT) || (op == ewq_pkg::OP_GIVEUP))) begin
              state <= ST_G_MASK;
            end else if (ev_ok && (op == ewq_pkg::OP_SEND)) begin
              state <= ST_S_USED;
            end else begin
              state <= ST_FINAL;
            end
          end
        end
        ST_G_MASK: begin
          scan  <= tm_rdata;
          state <= ST_G_NEXT;
        end
        ST_G_NEXT: begin
          if (scan == '0) begin
            if (op_r == ewq_pkg::OP_WAIT) begin
              scan  <= wmask;
              state <= ST_C_NEXT;
            end else begin
              state <= ST_FINAL;
            end
          end else begin
            scan[e_pick] <= 1'b0;
            cur_e        <= e_pick;
            state        <= ST_G_USED;
          end
        end
        ST_G_USED: begin
          cur_used <= used_rdata;
          pending  <= used_rdata;
          cmp_vld  <= 1'b0;
          state    <= ST_G_SLOT;
        end
        ST_G_SLOT: begin
          cur_used <= cur_used_n;
          if (pending == '0) begin
            cmp_vld <= 1'b0;
            state   <= ST_G_NEXT;
          end else begin
            pending[s_pick] <= 1'b0;
            cmp_s           <= s_pick;
            cmp_vld         <= 1'b1;
          end
        end
        ST_C_NEXT: begin
          if (scan == '0) begin
            scan  <= wmask;
            state <= ST_A_NEXT;
          end else begin
            scan[e_pick] <= 1'b0;
            state        <= ST_C_USED;
          end
        end
        ST_C_USED: begin
          if (&used_rdata) begin
            fin_status <= 1'b1;
            state      <= ST_FINAL;
          end else begin
            state <= ST_C_NEXT;
          end
        end
        ST_A_NEXT: begin
          if (scan == '0) begin
            state <= ST_FINAL;
          end else begin
            scan[e_pick] <= 1'b0;
            cur_e        <= e_pick;
            state        <= ST_A_USED;
          end
        end
        ST_A_USED: begin
          state <= ST_A_NEXT;
        end
        ST_S_USED: begin
          pending <= used_rdata;
          state   <= ST_S_SLOT;
        end
        ST_S_SLOT: begin
          if (pending == '0) begin
            fin_rv   <= pend_vld;
            fin_rt   <= pend_vld ? pend_task : '0;
            pend_vld <= 1'b0;
            state    <= ST_FINAL;
          end else begin
            pending[s_pick] <= 1'b0;
            state           <= ST_S_TASK;
          end
        end
        ST_S_TASK: begin
          t_reg <= st_rdata;
          state <= st_task_ok ? ST_S_MASK : ST_S_SLOT;
        end
        ST_S_MASK: begin
          if ((tm_rdata != '0) && (m_n == '0) && (32'(nrel) < ewq_pkg::MAX_RESULTS)) begin
            if (!pend_vld) begin
              pend_vld  <= 1'b1;
              pend_task <= t_reg;
              nrel      <= nrel + 1'b1;
              state     <= ST_S_SLOT;
            end else begin
              new_task <= t_reg;
              state    <= ST_S_PUSH;
            end
          end else begin
            state <= ST_S_SLOT;
          end
        end
        ST_S_PUSH: begin
          if (push_ok) begin
            pend_task <= new_task;
            nrel      <= nrel + 1'b1;
            state     <= ST_S_SLOT;
          end
        end
        ST_FINAL: begin
          if (push_ok) state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/event_wait_queue_unit.sv */
// Top level of the event wait-queue unit: sequencer, state memories and output register.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  op, task_id, event_mask, event_number
//   out      output     out_valid / out_stall  status, released_valid, released_task, last
//
// One item is worked on at a time; in_stall is high from the cycle after an item is
// accepted until its final result has been loaded into the output register.
// A give-up walks each event in the task's wait mask and compares every queued slot
// of it against the task; a wait does the same, then checks that no masked queue is
// full and claims a slot in each. A send walks the queued slots of its event and
// reads each owner's wait mask, clearing the event from it.
// Reset clears all control state and the valid bits of the bitmap and mask memories,
// so there is no clearing pass. A stalled output holds its item while the next input
// item may already be accepted; inner release items wait for the output register.
module event_wait_queue_unit #(
  parameter int NUM_EVENTS  = 32,
  parameter int QUEUE_SLOTS = 8,
  parameter int NUM_TASKS   = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [ewq_pkg::TASK_W-1:0]  task_id,
  input  logic [31:0]                 event_mask,
  input  logic [4:0]                  event_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        status,
  output logic                        released_valid,
  output logic [ewq_pkg::TASK_W-1:0]  released_task,
  output logic                        last
);

  localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int SW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int TW = $clog2(NUM_TASKS);
  localparam int AW = (NUM_EVENTS * QUEUE_SLOTS > 1) ? $clog2(NUM_EVENTS * QUEUE_SLOTS) : 1;

  logic                       seq_idle;
  ewq_pkg::push_t             push;
  logic                       push_ok;

  logic                       used_re;
  logic [EW-1:0]              used_raddr;
  logic [QUEUE_SLOTS-1:0]     used_rdata;
  logic                       used_we;
  logic [EW-1:0]              used_waddr;
  logic [QUEUE_SLOTS-1:0]     used_wdata;
  logic                       st_re;
  logic [AW-1:0]              st_raddr;
  logic [ewq_pkg::TASK_W-1:0] st_rdata;
  logic                       st_we;
  logic [AW-1:0]              st_waddr;
  logic [ewq_pkg::TASK_W-1:0] st_wdata;
  logic                       tm_re;
  logic [TW-1:0]              tm_raddr;
  logic [NUM_EVENTS-1:0]      tm_rdata;
  logic                       tm_we;
  logic [TW-1:0]              tm_waddr;
  logic [NUM_EVENTS-1:0]      tm_wdata;

  // The input side is open only while the sequencer has no item in hand.
  assign in_stall = !seq_idle;

  // The output register can take a new item when it is empty or being drained.
  assign push_ok = !out_valid || !out_stall;

  ewq_seq #(
    .NUM_EVENTS (NUM_EVENTS),
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .NUM_TASKS  (NUM_TASKS),
    .EW         (EW),
    .SW         (SW),
    .TW         (TW),
    .AW         (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .idle        (seq_idle),
    .op          (op),
    .task_id     (task_id),
    .event_mask  (event_mask),
    .event_number(event_number),
    .push        (push),
    .push_ok     (push_ok),
    .used_re     (used_re),
    .used_raddr  (used_raddr),
    .used_rdata  (used_rdata),
    .used_we     (used_we),
    .used_waddr  (used_waddr),
    .used_wdata  (used_wdata),
    .st_re       (st_re),
    .st_raddr    (st_raddr),
    .st_rdata    (st_rdata),
    .st_we       (st_we),
    .st_waddr    (st_waddr),
    .st_wdata    (st_wdata),
    .tm_re       (tm_re),
    .tm_raddr    (tm_raddr),
    .tm_rdata    (tm_rdata),
    .tm_we       (tm_we),
    .tm_waddr    (tm_waddr),
    .tm_wdata    (tm_wdata)
  );

  ewq_store #(
    .NUM_EVENTS (NUM_EVENTS),
    .QUEUE_SLOTS(QUEUE_SLOTS),
    .NUM_TASKS  (NUM_TASKS),
    .EW         (EW),
    .TW         (TW),
    .AW         (AW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .used_re   (used_re),
    .used_raddr(used_raddr),
    .used_rdata(used_rdata),
    .used_we   (used_we),
    .used_waddr(used_waddr),
    .used_wdata(used_wdata),
    .st_re     (st_re),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .tm_re     (tm_re),
    .tm_raddr  (tm_raddr),
    .tm_rdata  (tm_rdata),
    .tm_we     (tm_we),
    .tm_waddr  (tm_waddr),
    .tm_wdata  (tm_wdata)
  );

  // Output register. The valid flag is reset; the payload is loaded with each item.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid && push_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push_ok) begin
      status         <= push.status;
      released_valid <= push.rel_valid;
      released_task  <= push.rel_task;
      last           <= push.last;
    end
  end

  // An item without a released task always closes the results of its input item.
  a_norel_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !released_valid |-> last)
    else $error("result without a released task is not marked last");

  // A rejected wait never reports a release.
  a_reject_norel: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !released_valid)
    else $error("rejected wait carries a released task");

  // Once an item is accepted the input side closes for at least the next cycle.
  a_accept_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input side stayed open after an item was accepted");

  // A result item with no release carries task zero.
  a_norel_task: assert property (@(posedge clk) disable iff (rst)
    out_valid && !released_valid |-> released_task == '0)
    else $error("result without a release carries a nonzero task id");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the event wait-queue unit, with its scoreboard class.
`timescale 1ns / 100ps

module testbench;

  // One result item as the unit should present it on the output channel.
  typedef struct packed {
    bit                       status;
    bit                       rel_valid;
    bit [ewq_pkg::TASK_W-1:0] rel_task;
    bit                       last;
  } outcome_t;

  // Shadow copy of the wait queues. It tracks the slot bitmaps, the slot owners and
  // each task's wait mask, and it keeps the result items that are still owed.
  class ewq_shadow;
    bit [7:0]                 used_slots [32];
    bit [ewq_pkg::TASK_W-1:0] slot_owner [256];
    bit [31:0]                awaited [16];
    outcome_t                 owed [$];
    int                       mismatches;

    // Remove a task from every queue it sits in and forget what it waits for.
    function void drop_waiter(int unsigned tid);
      bit [31:0] m;
      m = awaited[tid];
      for (int e = 0; e < 32; e++) begin
        if (m[e]) begin
          for (int s = 0; s < 8; s++) begin
            if (used_slots[e][s] && slot_owner[e * 8 + s] == tid)
              used_slots[e][s] = 1'b0;
          end
        end
      end
      awaited[tid] = '0;
    endfunction

    // Returns 1 when the wait is turned away because one of its queues is full.
    function bit enter_waiter(int unsigned tid, bit [31:0] mask);
      drop_waiter(tid);
      for (int e = 0; e < 32; e++) begin
        if (mask[e] && used_slots[e] == 8'hFF)
          return 1'b1;
      end
      awaited[tid] = mask;
      for (int e = 0; e < 32; e++) begin
        if (mask[e]) begin
          for (int s = 0; s < 8; s++) begin
            if (!used_slots[e][s]) begin
              used_slots[e][s] = 1'b1;
              slot_owner[e * 8 + s] = tid;
              break;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_call(ewq_pkg::op_t code, bit [ewq_pkg::TASK_W-1:0] tid,
                            bit [31:0] mask, bit [4:0] evn);
      outcome_t o;
      int n;
      bit rejected;
      bit [ewq_pkg::TASK_W-1:0] t;
      n = 0;
      rejected = 1'b0;
      case (code)
        ewq_pkg::OP_WAIT: begin
          rejected = enter_waiter(tid, mask);
        end
        ewq_pkg::OP_SEND: begin
          for (int s = 0; s < 8; s++) begin
            if (!used_slots[evn][s])
              continue;
            t = slot_owner[evn * 8 + s];
            if (awaited[t] == 0)
              continue;
            awaited[t][evn] = 1'b0;
            if (awaited[t] == 0 && n < ewq_pkg::MAX_RESULTS) begin
              o = '{status: 1'b0, rel_valid: 1'b1, rel_task: t, last: 1'b0};
              owed.push_back(o);
              n++;
            end
          end
          used_slots[evn] = '0;
        end
        ewq_pkg::OP_GIVEUP: begin
          drop_waiter(tid);
        end
        default: begin
        end
      endcase
      if (n == 0) begin
        o = '{status: rejected, rel_valid: 1'b0, rel_task: '0, last: 1'b1};
        owed.push_back(o);
      end else begin
        owed[owed.size() - 1].last = 1'b1;
      end
    endfunction

    task report(string what, int want, int got);
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    endtask

    task check_outcome(bit st, bit rv, bit [ewq_pkg::TASK_W-1:0] rt, bit lst);
      outcome_t o;
      if (owed.size() == 0) begin
        report("unrequested result item", 0, 1);
      end else begin
        o = owed.pop_front();
        if (st != o.status) report("status", o.status, st);
        if (rv != o.rel_valid) report("released_valid", o.rel_valid, rv);
        if (rt != o.rel_task) report("released_task", o.rel_task, rt);
        if (lst != o.last) report("last", o.last, lst);
      end
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 op = ewq_pkg::OP_NONE;
  logic [ewq_pkg::TASK_W-1:0] task_id = '0;
  logic [31:0]                event_mask = '0;
  logic [4:0]                 event_number = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       status;
  logic                       released_valid;
  logic [ewq_pkg::TASK_W-1:0] released_task;
  logic                       last;

  // While set, neither side inserts idle cycles; used for one long burst.
  bit no_idle = 1'b0;

  ewq_shadow sb = new();

  event_wait_queue_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The output side stalls on roughly a third of the cycles, changing only on the
  // falling edge so that the unit always sees a settled value at the rising edge.
  always @(negedge clk) begin
    out_stall = !no_idle && ($urandom_range(0, 99) < 32);
  end

  // Both channels are observed at the rising edge. An input item and a result item
  // can be accepted at the same edge; the result always belongs to an earlier item,
  // so the order of the two calls does not matter for the owed list.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_call(ewq_pkg::op_t'(op), task_id, event_mask, event_number);
      if (out_valid && !out_stall)
        sb.check_outcome(status, released_valid, released_task, last);
    end
  end

  // Presents one item, called at a falling edge and returning at the falling edge
  // after acceptance. Valid stays high into the next item unless an idle gap is
  // drawn, so back-to-back items never see valid dropped and raised in one step.
  task automatic issue(ewq_pkg::op_t code, logic [ewq_pkg::TASK_W-1:0] tid,
                       logic [31:0] mask, logic [4:0] evn);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    op           = code;
    task_id      = tid;
    event_mask   = mask;
    event_number = evn;
    do
      @(posedge clk);
    while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int r;
    int k;
    logic [31:0] m;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. An empty wait mask is accepted and queues nothing, and an
    // unknown operation simply answers with one ok item.
    issue(ewq_pkg::OP_WAIT, 4'd0, 32'h0, 5'($urandom));
    issue(ewq_pkg::OP_NONE, 4'($urandom), $urandom, 5'($urandom));
    // Task 1 waits for every event, task 2 for the two outermost ones.
    issue(ewq_pkg::OP_WAIT, 4'd1, 32'hFFFF_FFFF, 5'($urandom));
    issue(ewq_pkg::OP_WAIT, 4'd2, 32'h8000_0001, 5'($urandom));
    // Event 31 completes nobody; event 0 then releases task 2 from slot 1.
    issue(ewq_pkg::OP_SEND, 4'($urandom), $urandom, 5'd31);
    issue(ewq_pkg::OP_SEND, 4'($urandom), $urandom, 5'd0);
    // A task that waits again first gives up its old wait.
    issue(ewq_pkg::OP_WAIT, 4'd1, 32'h0000_0002, 5'($urandom));
    issue(ewq_pkg::OP_GIVEUP, 4'd1, $urandom, 5'($urandom));
    // Fill every slot of event 5, then a wait that needs it is turned away whole.
    for (int i = 3; i <= 10; i++)
      issue(ewq_pkg::OP_WAIT, 4'(i), 32'h0000_0020, 5'($urandom));
    issue(ewq_pkg::OP_WAIT, 4'd11, 32'h0000_0060, 5'($urandom));
    // Re-waiting from a full queue frees the old slot and takes it back.
    issue(ewq_pkg::OP_WAIT, 4'd3, 32'h0000_0020, 5'($urandom));
    // A send that releases the largest number of tasks at once.
    issue(ewq_pkg::OP_SEND, 4'($urandom), $urandom, 5'd5);
    // Give-up of an idle task and a send to an empty queue change nothing.
    issue(ewq_pkg::OP_GIVEUP, 4'd15, $urandom, 5'($urandom));
    issue(ewq_pkg::OP_SEND, 4'($urandom), $urandom, 5'd9);
    issue(ewq_pkg::OP_WAIT, 4'd15, 32'hFFFF_FFFF, 5'($urandom));
    issue(ewq_pkg::OP_GIVEUP, 4'd15, $urandom, 5'($urandom));

    // Random part. Most waits and sends aim at a few hot events so that queues
    // fill up, waits get rejected and sends release several tasks. Now and then a
    // wide or fully random mask reaches the rest of the events.
    for (int i = 0; i < 400; i++) begin
      no_idle = (i >= 200 && i < 300);
      r = $urandom_range(0, 99);
      if (r < 50) begin
        k = $urandom_range(0, 99);
        if (k < 3) begin
          m = '0;
        end else if (k < 80) begin
          m = '0;
          repeat ($urandom_range(1, 3)) m[$urandom_range(0, 5)] = 1'b1;
        end else if (k < 93) begin
          m = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 5));
        end else begin
          m = $urandom;
        end
        issue(ewq_pkg::OP_WAIT, 4'($urandom), m, 5'($urandom));
      end else if (r < 80) begin
        if ($urandom_range(0, 99) < 85)
          issue(ewq_pkg::OP_SEND, 4'($urandom), $urandom, 5'($urandom_range(0, 5)));
        else
          issue(ewq_pkg::OP_SEND, 4'($urandom), $urandom, 5'($urandom_range(0, 31)));
      end else if (r < 97) begin
        issue(ewq_pkg::OP_GIVEUP, 4'($urandom), $urandom, 5'($urandom));
      end else begin
        issue(ewq_pkg::OP_NONE, 4'($urandom), $urandom, 5'($urandom));
      end
    end
    no_idle  = 1'b0;
    in_valid = 1'b0;

    // Every item yields at least one result, so once nothing is owed the unit is
    // idle; a short tail catches any stray result item.
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, with every item at its longest walk.
  initial begin
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

/* files.f */
rtl/core/ewq_pkg.sv
rtl/core/ewq_store.sv
rtl/core/ewq_seq.sv
rtl/core/event_wait_queue_unit.sv
dv/testbench.sv
